[rtl/huffman_tree_walk_decoder_macros.svh]
//------------------------------------------------------------------------------
// Huffman tree-walk decoder assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
//------------------------------------------------------------------------------
`ifndef HUFFMAN_TREE_WALK_DECODER_MACROS_SVH
`define HUFFMAN_TREE_WALK_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HTWD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HTWD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/htwd_pkg.sv]
//------------------------------------------------------------------------------
// Huffman tree-walk decoder package
// Widths, codes, node entry layout and controller types.
//------------------------------------------------------------------------------
package htwd_pkg;

  localparam int IDX_W          = 9;
  localparam int SYM_W          = 8;
  localparam int DEF_NODE_COUNT = 511;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 32;

  localparam logic       CMD_WRITE_NODE = 1'b0;
  localparam logic       CMD_DECODE     = 1'b1;
  localparam logic [0:0] REG_ROOT       = 1'b0;

  typedef struct packed {
    logic             leaf;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
    logic [SYM_W-1:0] sym;
  } node_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CUR,
    S_NXT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic mem_wr;
    logic rd_cur;
    logic rd_nxt;
    logic cur_nxt;
    logic emit;
  } htwd_cmd_t;

  typedef struct packed {
    logic leaf;
    logic out_free;
  } htwd_sts_t;

endpackage

[rtl/htwd_if.sv]
//------------------------------------------------------------------------------
// Huffman tree-walk decoder channel interfaces
// Valid/ready request channels for node and bit requests and for symbols.
//------------------------------------------------------------------------------
interface htwd_in_if;
  import htwd_pkg::*;

  logic             valid;
  logic             ready;
  logic             command;
  logic [IDX_W-1:0] node_index;
  logic [IDX_W-1:0] left_child;
  logic [IDX_W-1:0] right_child;
  logic             leaf_mark;
  logic [SYM_W-1:0] leaf_symbol;
  logic             code_bit;

  modport source (
    output valid, command, node_index, left_child, right_child, leaf_mark,
           leaf_symbol, code_bit,
    input  ready
  );

  modport sink (
    input  valid, command, node_index, left_child, right_child, leaf_mark,
           leaf_symbol, code_bit,
    output ready
  );
endinterface

interface htwd_out_if;
  import htwd_pkg::*;

  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;

  modport source (output valid, symbol, input ready);
  modport sink (input valid, symbol, output ready);
endinterface

[rtl/huffman_tree_walk_decoder.sv]
// A node write request is taken in S_IDLE; the block is ready again in the next cycle.
// A decode bit request walks S_IDLE, S_CUR, S_NXT, S_IDLE if no leaf is reached, else goes to
// S_EMIT from S_CUR or S_NXT where the leaf is found, set by the two dependent reads of the
// single-port node table with registered read data; the symbol waits in an output register.
// Synchronous active-low reset clears the controller, the walk position, the root register
// and the output valid; the node table is not cleared and needs no sweep.
//------------------------------------------------------------------------------
// Huffman tree-walk decoder top level
// Bit-serial Huffman decoder with a loadable node table and an APB root register.
//------------------------------------------------------------------------------
module huffman_tree_walk_decoder #(
  parameter int NODE_COUNT = htwd_pkg::DEF_NODE_COUNT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  htwd_in_if.sink                         in_ch,
  htwd_out_if.source                      out_ch,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [htwd_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [htwd_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [htwd_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import htwd_pkg::*;

  htwd_cmd_t        cmd;
  htwd_sts_t        sts;
  node_t            wr_node;
  logic             root_we;
  logic [IDX_W-1:0] root_q;
  logic [0:0]       reg_sel;

  assign reg_sel    = cfg_paddr[CFG_ADDR_W-1:2];
  assign cfg_pready = 1'b1;
  assign root_we    = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && reg_sel == REG_ROOT;
  assign cfg_prdata = (reg_sel == REG_ROOT) ? CFG_DATA_W'(root_q) : '0;

  assign wr_node.leaf  = in_ch.leaf_mark;
  assign wr_node.left  = in_ch.left_child;
  assign wr_node.right = in_ch.right_child;
  assign wr_node.sym   = in_ch.leaf_symbol;

  htwd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ch.ready),
    .cmd        (cmd),
    .sts        (sts)
  );

  htwd_dpath #(
    .NODE_COUNT (NODE_COUNT)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .root_we    (root_we),
    .root_wdata (cfg_pwdata[IDX_W-1:0]),
    .root_q     (root_q),
    .wr_index   (in_ch.node_index),
    .wr_node    (wr_node),
    .code_bit   (in_ch.code_bit),
    .out_valid  (out_ch.valid),
    .out_symbol (out_ch.symbol),
    .out_ready  (out_ch.ready)
  );

endmodule

[rtl/htwd_ctrl.sv]
//------------------------------------------------------------------------------
// Huffman tree-walk decoder controller
// Sequences node writes, the two table reads of a bit, and symbol hand-off.
//------------------------------------------------------------------------------
`include "huffman_tree_walk_decoder_macros.svh"

module htwd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_command,
  output logic                in_ready,
  output htwd_pkg::htwd_cmd_t cmd,
  input  htwd_pkg::htwd_sts_t sts
);
  import htwd_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_command == CMD_DECODE) begin
          state_nxt = S_CUR;
        end
      end
      S_CUR: begin
        state_nxt = sts.leaf ? S_EMIT : S_NXT;
      end
      S_NXT: begin
        state_nxt = sts.leaf ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.mem_wr = in_valid && in_command == CMD_WRITE_NODE;
        cmd.rd_cur = in_valid && in_command == CMD_DECODE;
      end
      S_CUR: begin
        cmd.rd_nxt = !sts.leaf;
      end
      S_NXT: begin
        cmd.cur_nxt = !sts.leaf;
      end
      S_EMIT: begin
        cmd.emit = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  `HTWD_ASSERT_NOW(a_single_action, 1'b1, $onehot0(cmd), "More than one datapath action in a cycle.")

endmodule

[rtl/htwd_dpath.sv]
//------------------------------------------------------------------------------
// Huffman tree-walk decoder datapath
// Node table memory, walk position, root register and symbol output register.
//------------------------------------------------------------------------------
`include "huffman_tree_walk_decoder_macros.svh"

module htwd_dpath #(
  parameter int NODE_COUNT = htwd_pkg::DEF_NODE_COUNT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  htwd_pkg::htwd_cmd_t        cmd,
  output htwd_pkg::htwd_sts_t        sts,
  input  logic                       root_we,
  input  logic [htwd_pkg::IDX_W-1:0] root_wdata,
  output logic [htwd_pkg::IDX_W-1:0] root_q,
  input  logic [htwd_pkg::IDX_W-1:0] wr_index,
  input  htwd_pkg::node_t            wr_node,
  input  logic                       code_bit,
  output logic                       out_valid,
  output logic [htwd_pkg::SYM_W-1:0] out_symbol,
  input  logic                       out_ready
);
  import htwd_pkg::*;

  localparam int               ADDR_W   = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam logic [IDX_W+1:0] NODE_LIM = (IDX_W + 2)'(NODE_COUNT);

  node_t            mem [NODE_COUNT];
  node_t            rd_q_r;
  node_t            ent;
  logic             rd_oob_r, rd_oob_nxt;
  logic [IDX_W-1:0] cur_r, cur_nxt;
  logic [IDX_W-1:0] root_r, root_nxt;
  logic [IDX_W-1:0] child_r, child_nxt;
  logic             bit_r, bit_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0] out_sym_r, out_sym_nxt;
  logic [IDX_W-1:0] child_addr;
  logic [IDX_W-1:0] rd_addr;
  logic             rd_en;
  logic             rd_in_range;
  logic             wr_in_range;

  // Entries beyond the table read as an inner node with both children zero.
  always_comb begin
    ent = rd_q_r;
    if (rd_oob_r) begin
      ent = '0;
    end
  end

  assign child_addr  = bit_r ? ent.right : ent.left;
  assign rd_en       = cmd.rd_cur || cmd.rd_nxt;
  assign rd_addr     = cmd.rd_nxt ? child_addr : cur_r;
  assign rd_in_range = {2'b00, rd_addr} < NODE_LIM;
  assign wr_in_range = {2'b00, wr_index} < NODE_LIM;

  always_ff @(posedge clk) begin
    if (cmd.mem_wr && wr_in_range) begin
      mem[ADDR_W'(wr_index)] <= wr_node;
    end
    if (rd_en) begin
      rd_q_r <= mem[ADDR_W'(rd_addr)];
    end
  end

  always_comb begin
    root_nxt      = root_we ? root_wdata : root_r;
    rd_oob_nxt    = rd_en ? !rd_in_range : rd_oob_r;
    child_nxt     = cmd.rd_nxt ? child_addr : child_r;
    bit_nxt       = cmd.rd_cur ? code_bit : bit_r;
    out_sym_nxt   = cmd.emit ? ent.sym : out_sym_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end
    cur_nxt = cur_r;
    if (root_we) begin
      cur_nxt = root_wdata;
    end else if (cmd.emit) begin
      cur_nxt = root_r;
    end else if (cmd.cur_nxt) begin
      cur_nxt = child_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= '0;
      root_r      <= '0;
      rd_oob_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_r       <= cur_nxt;
      root_r      <= root_nxt;
      rd_oob_r    <= rd_oob_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    child_r   <= child_nxt;
    bit_r     <= bit_nxt;
    out_sym_r <= out_sym_nxt;
  end

  assign sts.leaf     = ent.leaf;
  assign sts.out_free = !out_valid_r || out_ready;
  assign root_q       = root_r;
  assign out_valid    = out_valid_r;
  assign out_symbol   = out_sym_r;

  `HTWD_ASSERT_NOW(a_no_overwrite, cmd.emit, !out_valid_r || out_ready, "Symbol overwritten before it was taken.")
  `HTWD_ASSERT_NEXT(a_root_return, cmd.emit, cur_r == root_r, "Walk did not return to the root after a leaf.")
  `HTWD_ASSERT_NEXT(a_emit_shows, cmd.emit, out_valid_r, "Emitted symbol not presented on the output.")

endmodule
